/* design/fla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_pkg
// Shared codes and types of the free-list allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  // fit strategy register codes (code 3 acts as first fit)
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // control from the sequencer to the statistics unit
  typedef struct packed {
    logic clr;
    logic acc;
  } stat_ctl_t;

endpackage

/* design/fla_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_store
// Extent table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fla_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int LW    = 33
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [LW-1:0] woff_i,
  input  logic [LW-1:0] wlen_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [LW-1:0] roff_o,
  output logic [LW-1:0] rlen_o
);

  logic [2*LW-1:0] mem_q [DEPTH];
  logic [2*LW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wlen_i, woff_i};
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign roff_o = rd_q[LW-1:0];
  assign rlen_o = rd_q[2*LW-1:LW];

endmodule

/* design/fla_stats.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fla_stats
// Running sum and maximum of extent lengths, saturated to 32 bits.
// ----------------------------------------------------------------------------
module fla_stats
  import fla_pkg::*;
#(
  parameter int LW = 33,
  parameter int TW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stat_ctl_t     ctl_i,
  input  logic [LW-1:0] len_i,
  output logic [31:0]   total_o,
  output logic [31:0]   largest_o
);

  logic [TW-1:0] tot_q, tot_d;
  logic [LW-1:0] max_q, max_d;

  always_comb begin
    tot_d = tot_q;
    max_d = max_q;
    if (ctl_i.clr) begin
      tot_d = '0;
      max_d = '0;
    end else if (ctl_i.acc) begin
      tot_d = tot_q + TW'(len_i);
      if (len_i > max_q) begin
        max_d = len_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      max_q <= '0;
    end else begin
      tot_q <= tot_d;
      max_q <= max_d;
    end
  end

  assign total_o   = ((tot_q >> 32) != '0) ? 32'hFFFF_FFFF : 32'(tot_q);
  assign largest_o = ((max_q >> 32) != '0) ? 32'hFFFF_FFFF : 32'(max_q);

endmodule

/* design/free_list_allocator_coalescing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_allocator_coalescing
// Free-extent allocator: first/best/worst fit, coalescing on free.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: tuser[0] = mode (0 allocate,
//   1 free), tdata = region_offset then region_length. m_axis returns one
//   result per request: tuser = status, tdata = granted_offset, total_free,
//   largest_free, extent_count. cfg_* writes fit_strategy (always ready).
//   Every request is handled by a sequencer around one table RAM with a
//   single read and a single write port, one entry per cycle:
//     scan pass   : first fit stops at the hit, a free at the next extent above
//     shift pass  : when an extent is removed/inserted
//     stats pass  : sums lengths and finds the largest
//   plus accept, decide and result steps.
//   s_axis_tready is high only while the sequencer is idle. A finished
//   result sits in an output register; a new request is taken while it
//   waits, but the next result is held back until the receiver takes the
//   previous one.
//   Reset empties the table (extent count zero, no clearing pass needed)
//   and sets first fit.
// ----------------------------------------------------------------------------
module free_list_allocator_coalescing
  import fla_pkg::*;
#(
  parameter int MAX_EXTENTS = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // [31:0] region_offset, [63:32] region_length
  input  logic [0:0]   s_axis_tuser,   // [0] mode
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [31:0] granted_offset, [63:32] total_free,
                                       // [95:64] largest_free, [102:96] extent_count
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  // configuration
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i      // fit_strategy
);

  localparam int LW = ADDR_BITS + 1;               // merged extents never wrap
  localparam int IW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int TW = LW + CW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHDN   = 3'd3;
  localparam logic [2:0] S_SHUP   = 3'd4;
  localparam logic [2:0] S_STAT   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    strat_q;
  logic          mode_q, mode_d;
  logic [LW-1:0] off_q, off_d, len_q, len_d;
  logic [1:0]    status_q, status_d;
  logic [LW-1:0] granted_q, granted_d;

  // read pipeline
  logic [CW-1:0] iss_q, iss_d, ridx_q, ridx_d;
  logic          rv_q, rv_d, stop_q, stop_d;

  // scan results
  logic          found_q, found_d;
  logic [CW-1:0] pick_q, pick_d, pos_q, pos_d;
  logic [LW-1:0] pk_off_q, pk_off_d, pk_len_q, pk_len_d, metric_q, metric_d;
  logic [LW-1:0] pv_off_q, pv_off_d, pv_len_q, pv_len_d;
  logic [LW-1:0] nx_off_q, nx_off_d, nx_len_q, nx_len_d;
  logic          have_pv_q, have_pv_d, have_nx_q, have_nx_d;

  // output register
  logic          ov_q, ov_d;
  logic [103:0]  od_q, od_d;
  logic [1:0]    ou_q, ou_d;

  // table port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [LW-1:0] mem_woff, mem_wlen, rd_off, rd_len;

  stat_ctl_t     sctl;
  logic [31:0]   st_total, st_largest;
  logic [6:0]    cnt_sat;

  logic          fits, back, fwd;
  logic [LW-1:0] waste;

  fla_store #(.DEPTH(MAX_EXTENTS), .AW(AW), .LW(LW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .woff_i  (mem_woff),
    .wlen_i  (mem_wlen),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .roff_o  (rd_off),
    .rlen_o  (rd_len)
  );

  assign sctl.clr = (state_q == S_IDLE);
  assign sctl.acc = (state_q == S_STAT) && rv_q;

  fla_stats #(.LW(LW), .TW(TW)) u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sctl),
    .len_i     (rd_len),
    .total_o   (st_total),
    .largest_o (st_largest)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

  assign cnt_sat = (cnt_q > CW'(127)) ? 7'd127 : 7'(cnt_q);
  assign fits    = (rd_len >= len_q);
  assign waste   = rd_len - len_q;
  assign back    = have_pv_q && ((pv_off_q + pv_len_q) == off_q);
  assign fwd     = have_nx_q && (nx_off_q == (off_q + len_q));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    mode_d    = mode_q;
    off_d     = off_q;
    len_d     = len_q;
    status_d  = status_q;
    granted_d = granted_q;
    iss_d     = iss_q;
    stop_d    = stop_q;
    found_d   = found_q;
    pick_d    = pick_q;
    pos_d     = pos_q;
    pk_off_d  = pk_off_q;
    pk_len_d  = pk_len_q;
    metric_d  = metric_q;
    pv_off_d  = pv_off_q;
    pv_len_d  = pv_len_q;
    nx_off_d  = nx_off_q;
    nx_len_d  = nx_len_q;
    have_pv_d = have_pv_q;
    have_nx_d = have_nx_q;
    ov_d      = ov_q;
    od_d      = od_q;
    ou_d      = ou_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_woff  = '0;
    mem_wlen  = '0;
    mem_re    = 1'b0;
    mem_raddr = iss_q[AW-1:0];
    ridx_d    = iss_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    // forward read sweep used by scan, shift-down and stats passes
    if ((state_q == S_SCAN || state_q == S_SHDN || state_q == S_STAT) &&
        !stop_q && (iss_q < cnt_q)) begin
      mem_re = 1'b1;
      iss_d  = iss_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d    = s_axis_tuser[0];
          off_d     = LW'(s_axis_tdata[IW-1:0]);
          len_d     = LW'(s_axis_tdata[32+IW-1:32]);
          granted_d = '0;
          status_d  = ST_OK;
          iss_d     = '0;
          stop_d    = 1'b0;
          found_d   = 1'b0;
          pos_d     = '0;
          have_pv_d = 1'b0;
          have_nx_d = 1'b0;
          if (s_axis_tdata[32+IW-1:32] == '0) begin
            status_d = ST_ZERO;
            state_d  = S_STAT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rv_q && !stop_q) begin
          if (mode_q == MODE_ALLOC) begin
            if (fits) begin
              case (strat_q)
                FIT_BEST: begin
                  if (!found_q || waste < metric_q) begin
                    found_d = 1'b1; pick_d = ridx_q; metric_d = waste;
                    pk_off_d = rd_off; pk_len_d = rd_len;
                  end
                end
                FIT_WORST: begin
                  if (!found_q || rd_len > metric_q) begin
                    found_d = 1'b1; pick_d = ridx_q; metric_d = rd_len;
                    pk_off_d = rd_off; pk_len_d = rd_len;
                  end
                end
                default: begin
                  found_d = 1'b1; pick_d = ridx_q; stop_d = 1'b1;
                  pk_off_d = rd_off; pk_len_d = rd_len;
                end
              endcase
            end
          end else begin
            if (rd_off < off_q) begin
              have_pv_d = 1'b1; pv_off_d = rd_off; pv_len_d = rd_len;
              pos_d = ridx_q + 1'b1;
            end else begin
              have_nx_d = 1'b1; nx_off_d = rd_off; nx_len_d = rd_len;
              stop_d = 1'b1;
            end
          end
        end
        if (stop_q || (iss_q == cnt_q && !rv_q)) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        stop_d = 1'b0;
        iss_d  = '0;
        state_d = S_STAT;
        if (mode_q == MODE_ALLOC) begin
          if (!found_q) begin
            status_d = ST_NOFIT;
          end else begin
            granted_d = pk_off_q;
            if (pk_len_q == len_q) begin
              iss_d   = pick_q + 1'b1;
              state_d = S_SHDN;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pick_q[AW-1:0];
              mem_woff  = pk_off_q + len_q;
              mem_wlen  = pk_len_q - len_q;
            end
          end
        end else if (back) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_q - 1'b1);
          mem_woff  = pv_off_q;
          mem_wlen  = pv_len_q + len_q + (fwd ? nx_len_q : '0);
          if (fwd) begin
            iss_d   = pos_q + 1'b1;
            state_d = S_SHDN;
          end
        end else if (fwd) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          mem_woff  = off_q;
          mem_wlen  = nx_len_q + len_q;
        end else if (cnt_q >= CNT_MAX) begin
          status_d = ST_FULL;
        end else if (pos_q == cnt_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          mem_woff  = off_q;
          mem_wlen  = len_q;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          iss_d   = cnt_q - 1'b1;
          state_d = S_SHUP;
        end
      end

      S_SHDN: begin
        // entry i+1 moves to i
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ridx_q - 1'b1);
          mem_woff  = rd_off;
          mem_wlen  = rd_len;
        end
        if (iss_q == cnt_q && !rv_q) begin
          cnt_d   = cnt_q - 1'b1;
          iss_d   = '0;
          state_d = S_STAT;
        end
      end

      S_SHUP: begin
        // entry i moves to i+1, from the top down to the insert point
        if (!stop_q) begin
          mem_re = 1'b1;
          if (iss_q == pos_q) begin
            stop_d = 1'b1;
          end else begin
            iss_d = iss_q - 1'b1;
          end
        end
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ridx_q + 1'b1);
          mem_woff  = rd_off;
          mem_wlen  = rd_len;
        end else if (stop_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          mem_woff  = off_q;
          mem_wlen  = len_q;
          cnt_d     = cnt_q + 1'b1;
          stop_d    = 1'b0;
          iss_d     = '0;
          state_d   = S_STAT;
        end
      end

      S_STAT: begin
        if (iss_q == cnt_q && !rv_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          od_d    = {1'b0, cnt_sat, st_largest, st_total, 32'(granted_q)};
          ou_d    = status_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rv_d = mem_re;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      strat_q <= FIT_FIRST;
      rv_q    <= 1'b0;
      stop_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      stop_q  <= stop_d;
      ov_q    <= ov_d;
      if (cfg_valid_i) begin
        strat_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    off_q     <= off_d;
    len_q     <= len_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    iss_q     <= iss_d;
    ridx_q    <= ridx_d;
    found_q   <= found_d;
    pick_q    <= pick_d;
    pos_q     <= pos_d;
    pk_off_q  <= pk_off_d;
    pk_len_q  <= pk_len_d;
    metric_q  <= metric_d;
    pv_off_q  <= pv_off_d;
    pv_len_q  <= pv_len_d;
    nx_off_q  <= nx_off_d;
    nx_len_q  <= nx_len_d;
    have_pv_q <= have_pv_d;
    have_nx_q <= have_nx_d;
    od_q      <= od_d;
    ou_q      <= ou_d;
  end

  // table never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_MAX)
    else $error("extent count beyond table depth");

  // writes stay inside the occupied part of the table plus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_waddr) <= cnt_q))
    else $error("table write beyond occupied entries");

  // an insert shift only starts with room left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHUP) |-> (cnt_q < CNT_MAX))
    else $error("insert shift on a full table");

endmodule
